/* hw/rtl/mlqs_pkg.sv */
// shared types and constants for the multilevel queue scheduler
package mlqs_pkg;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] CLASS_RT   = 2'd0;
   localparam logic [1:0] CLASS_SYS  = 2'd1;
   localparam logic [1:0] CLASS_USER = 2'd2;
   localparam logic [1:0] CLASS_BAD  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_OUT
   } state_type;

   // one ready-store entry
   typedef struct packed {
      logic        valid;
      logic        user;
      logic [7:0]  prio;
      logic [15:0] work;
      logic [15:0] key;
      logic [31:0] last_use;
   } entry_type;

   // candidate travelling down the chain
   typedef struct packed {
      logic        found;
      logic [7:0]  prio;
      logic [15:0] work;
      logic [15:0] key;
      logic [31:0] last_use;
   } cand_type;

   // per-cell command from the controller
   typedef struct packed {
      logic        load;
      logic        write;
      logic        dec;
      logic        user;
      logic [31:0] stamp;
      entry_type   data;
   } cell_ctl_type;

   function automatic logic goes_before(input logic user, input cand_type a,
                                        input cand_type b);
      logic r;
      begin
         if (!b.found) r = a.found;
         else if (!a.found) r = 1'b0;
         else if (a.prio != b.prio) r = (a.prio > b.prio);
         else if (user && a.last_use != b.last_use) r = (a.last_use < b.last_use);
         else if (!user && a.work != b.work) r = (a.work < b.work);
         else r = (a.key < b.key);
         return r;
      end
   endfunction

endpackage

/* hw/rtl/multilevel_queue_scheduler_core.sv */
// top level of the multilevel queue scheduler
// usage: req_ carries add or tick transactions, rsp_ returns one result per
// transaction. one transaction is taken at a time; req_stall is high while
// a transaction is in work or its result waits. an add goes through the
// apply state and its result is offered in the output state. a tick runs
// two scans of the ready chain (system then user) before apply; the next
// transaction is taken in the cycle after the result leaves. that chain
// walk sets the rate.
// real-time ticks use the same path. the winner of each scan is found by
// comparing one cell per cycle: the chosen slot index walks alongside the
// candidate.
// reset clears the ring pointers, all ready valid bits, the turn and the
// tick counter; no clearing pass is needed. a result held by rsp_stall
// keeps rsp_ fields stable and holds off new requests.
module multilevel_queue_scheduler_core #(
   parameter int RT_DEPTH    = 16,
   parameter int READY_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_job_class,
   input  logic [15:0] req_name_key,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_work_units,
   input  logic [31:0] req_last_use_init,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_served,
   output logic [15:0] rsp_served_key,
   output logic        rsp_finished,
   output logic [31:0] rsp_tick_number,
   output logic        rsp_add_rejected,
   output logic        rsp_all_empty
);

   localparam int RW = $clog2(RT_DEPTH);
   localparam int CW = $clog2(RT_DEPTH + 1);
   localparam int SW = $clog2(READY_DEPTH);
   localparam int NW = $clog2(READY_DEPTH + 2);

   mlqs_pkg::state_type state_ff, state_in;

   logic [15:0] rt_key_ff [RT_DEPTH];
   logic [15:0] rt_work_ff [RT_DEPTH];
   logic [RW-1:0] rt_head_ff;
   logic [CW-1:0] rt_count_ff;
   logic          user_turn_ff;
   logic [31:0]   tick_ff;

   logic          cmd_ff;
   logic [1:0]    cls_ff;
   logic [15:0]   key_ff;
   logic [7:0]    prio_ff;
   logic [15:0]   work_ff;
   logic [31:0]   last_ff;

   logic          pass_ff;       // 0 system scan, 1 user scan
   logic [NW-1:0] cnt_ff;
   logic          sys_found_ff;
   logic [SW-1:0] sys_slot_ff;
   logic [15:0]   sys_key_ff;

   logic          o_served_ff, o_fin_ff, o_rej_ff, o_valid_ff;
   logic          o_empty;
   logic [15:0]   o_key_ff;
   logic [31:0]   o_tick_ff;

   mlqs_pkg::cell_ctl_type ctl;
   mlqs_pkg::cand_type     chain [READY_DEPTH+1];
   logic [READY_DEPTH-1:0] cell_valid, cell_last, cell_take, sel;
   logic [SW-1:0]          slot_pipe_ff [READY_DEPTH];
   logic [SW-1:0]          free_slot;
   logic                   free_found;

   assign chain[0] = '0;

   // index of the winner travels with the candidate
   genvar g;
   generate
      for (g = 0; g < READY_DEPTH; g++) begin : g_cell
         mlqs_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .sel       (sel[g]),
            .cand_in   (chain[g]),
            .cand_out  (chain[g+1]),
            .take      (cell_take[g]),
            .valid     (cell_valid[g]),
            .last_work (cell_last[g])
         );
         if (g == 0) begin : g_first
            always_ff @(posedge clock) slot_pipe_ff[g] <= SW'(g);
         end else begin : g_rest
            always_ff @(posedge clock) begin
               if (cell_take[g]) slot_pipe_ff[g] <= SW'(g);
               else slot_pipe_ff[g] <= slot_pipe_ff[g-1];
            end
         end
      end
   endgenerate

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = READY_DEPTH - 1; i >= 0; i--) begin
         if (!cell_valid[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   logic          winner_found;
   logic [SW-1:0] winner_slot;
   assign winner_found = chain[READY_DEPTH].found;
   assign winner_slot  = slot_pipe_ff[READY_DEPTH-1];

   // decide the serve at the end of the user scan, the add checks and the ring tail and next head
   logic          use_user, do_ready, rt_do, rt_add_ok, add_ok, bad;
   logic [SW-1:0] srv_slot;
   logic [RW-1:0] rt_tail, rt_next_head;
   logic [RW:0]   rt_sum;
   always_comb begin
      if (!user_turn_ff) use_user = !sys_found_ff;
      else use_user = winner_found;
      do_ready = use_user ? winner_found : sys_found_ff;
      srv_slot = use_user ? winner_slot : sys_slot_ff;
      bad = (work_ff == 16'd0) || (cls_ff == mlqs_pkg::CLASS_BAD);
      rt_add_ok = !bad && (cls_ff == mlqs_pkg::CLASS_RT) &&
                  (rt_count_ff != CW'(RT_DEPTH));
      add_ok = !bad && (cls_ff != mlqs_pkg::CLASS_RT) && free_found;
      rt_do = (rt_count_ff != '0);
      rt_sum = {1'b0, rt_head_ff} + (RW+1)'(rt_count_ff);
      if (rt_sum >= (RW+1)'(RT_DEPTH)) rt_tail = RW'(rt_sum - (RW+1)'(RT_DEPTH));
      else rt_tail = RW'(rt_sum);
      if (rt_head_ff == RW'(RT_DEPTH - 1)) rt_next_head = '0;
      else rt_next_head = rt_head_ff + RW'(1);
   end

   always_comb begin
      ctl        = '0;
      ctl.user   = pass_ff;
      ctl.stamp  = tick_ff;
      ctl.data.valid    = 1'b1;
      ctl.data.user     = (cls_ff == mlqs_pkg::CLASS_USER);
      ctl.data.prio     = prio_ff;
      ctl.data.work     = work_ff;
      ctl.data.key      = key_ff;
      ctl.data.last_use = last_ff;
      sel = '0;
      ctl.load = (state_ff == mlqs_pkg::ST_IDLE);
      if (state_ff == mlqs_pkg::ST_APPLY) begin
         if (cmd_ff == mlqs_pkg::CMD_ADD) begin
            ctl.write = add_ok;
            sel[free_slot] = 1'b1;
         end else if (!rt_do) begin
            ctl.dec = do_ready;
            sel[srv_slot] = 1'b1;
         end
      end
   end

   logic [15:0] rt_hk, rt_hw;
   assign rt_hk = rt_key_ff[rt_head_ff];
   assign rt_hw = rt_work_ff[rt_head_ff];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlqs_pkg::ST_IDLE:  if (req_valid) begin
            state_in = (req_cmd == mlqs_pkg::CMD_TICK) ? mlqs_pkg::ST_SCAN :
                       mlqs_pkg::ST_APPLY;
         end
         mlqs_pkg::ST_SCAN:  if (pass_ff && cnt_ff == NW'(READY_DEPTH)) begin
            state_in = mlqs_pkg::ST_APPLY;
         end
         mlqs_pkg::ST_APPLY: state_in = mlqs_pkg::ST_OUT;
         mlqs_pkg::ST_OUT:   if (!rsp_stall) state_in = mlqs_pkg::ST_IDLE;
         default:            state_in = mlqs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mlqs_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == mlqs_pkg::ST_IDLE && req_valid) begin
         cmd_ff  <= req_cmd;
         cls_ff  <= req_job_class;
         key_ff  <= req_name_key;
         prio_ff <= req_priority_req;
         work_ff <= req_work_units;
         last_ff <= req_last_use_init;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (state_ff == mlqs_pkg::ST_SCAN) begin
         if (cnt_ff == NW'(READY_DEPTH)) begin
            if (!pass_ff) begin
               sys_found_ff <= winner_found;
               sys_slot_ff  <= winner_slot;
               sys_key_ff   <= chain[READY_DEPTH].key;
            end
            pass_ff <= ~pass_ff;
            cnt_ff  <= '0;
         end else begin
            cnt_ff <= cnt_ff + NW'(1);
         end
      end else begin
         pass_ff <= 1'b0;
         cnt_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_head_ff   <= '0;
         rt_count_ff  <= '0;
         user_turn_ff <= 1'b0;
         tick_ff      <= '0;
         o_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == mlqs_pkg::ST_OUT && !rsp_stall) o_valid_ff <= 1'b0;
         if (state_ff == mlqs_pkg::ST_APPLY) begin
            o_valid_ff  <= 1'b1;
            o_served_ff <= 1'b0;
            o_key_ff    <= '0;
            o_fin_ff    <= 1'b0;
            o_tick_ff   <= '0;
            o_rej_ff    <= 1'b0;
            if (cmd_ff == mlqs_pkg::CMD_ADD) begin
               o_rej_ff <= !(rt_add_ok || add_ok);
               if (rt_add_ok) begin
                  rt_key_ff[rt_tail]  <= key_ff;
                  rt_work_ff[rt_tail] <= work_ff;
                  rt_count_ff <= rt_count_ff + CW'(1);
               end
            end else begin
               o_tick_ff <= tick_ff;
               tick_ff   <= tick_ff + 32'd1;
               if (rt_do) begin
                  o_served_ff <= 1'b1;
                  o_key_ff    <= rt_hk;
                  rt_head_ff  <= rt_next_head;
                  if (rt_hw == 16'd1) begin
                     o_fin_ff    <= 1'b1;
                     rt_count_ff <= rt_count_ff - CW'(1);
                  end else begin
                     rt_key_ff[rt_tail]  <= rt_hk;
                     rt_work_ff[rt_tail] <= rt_hw - 16'd1;
                  end
               end else if (do_ready) begin
                  o_served_ff <= 1'b1;
                  o_key_ff    <= use_user ? chain[READY_DEPTH].key : sys_key_ff;
                  o_fin_ff    <= cell_last[srv_slot];
                  if (use_user != user_turn_ff) user_turn_ff <= user_turn_ff;
                  else user_turn_ff <= ~user_turn_ff;
               end
            end
         end
      end
   end

   // all_empty is combinational; it is read in the output state that follows apply, when cells have updated
   always_comb begin
      o_empty = (rt_count_ff == '0) && (cell_valid == '0);
   end

   assign req_stall        = (state_ff != mlqs_pkg::ST_IDLE);
   assign rsp_valid        = o_valid_ff;
   assign rsp_served       = o_served_ff;
   assign rsp_served_key   = o_key_ff;
   assign rsp_finished     = o_fin_ff;
   assign rsp_tick_number  = o_tick_ff;
   assign rsp_add_rejected = o_rej_ff;
   assign rsp_all_empty    = o_empty;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == mlqs_pkg::ST_OUT))
      else $error("result valid outside output state");
   assert property (@(posedge clock) disable iff (reset)
      rt_count_ff <= CW'(RT_DEPTH))
      else $error("real-time ring overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_add_rejected) |-> !rsp_served)
      else $error("rejected add reports a serve");

endmodule

/* hw/rtl/mlqs_cell.sv */
// one ready-store cell: holds an entry and passes the best candidate to its neighbor
module mlqs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mlqs_pkg::cell_ctl_type ctl,
   input  logic                  sel,
   input  mlqs_pkg::cand_type    cand_in,
   output mlqs_pkg::cand_type    cand_out,
   output logic                  take,
   output logic                  valid,
   output logic                  last_work
);

   mlqs_pkg::entry_type entry_ff;
   mlqs_pkg::cand_type  mine;
   mlqs_pkg::cand_type  cand_ff;

   always_comb begin
      mine.found    = entry_ff.valid && (entry_ff.user == ctl.user);
      mine.prio     = entry_ff.prio;
      mine.work     = entry_ff.work;
      mine.key      = entry_ff.key;
      mine.last_use = entry_ff.last_use;
   end

   // own entry is taken when it goes before the best candidate from lower slots; on a full tie the incoming one stays
   assign take = mlqs_pkg::goes_before(ctl.user, mine, cand_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (ctl.write && sel) begin
         entry_ff <= ctl.data;
      end else if (ctl.dec && sel) begin
         entry_ff.work     <= entry_ff.work - 16'd1;
         entry_ff.last_use <= ctl.stamp;
         if (entry_ff.work == 16'd1) entry_ff.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) cand_ff <= '0;
      else if (take) cand_ff <= mine;
      else cand_ff <= cand_in;
   end

   assign cand_out  = cand_ff;
   assign valid     = entry_ff.valid;
   assign last_work = (entry_ff.work == 16'd1);

endmodule

/* tb/mlqs_checker.sv */
// checker for the multilevel queue scheduler: watches both channels, predicts and compares
`timescale 1ns / 100ps
module mlqs_checker #(
   parameter int RT_DEPTH    = 16,
   parameter int READY_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_job_class,
   input  logic [15:0] req_name_key,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_work_units,
   input  logic [31:0] req_last_use_init,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_served,
   input  logic [15:0] rsp_served_key,
   input  logic        rsp_finished,
   input  logic [31:0] rsp_tick_number,
   input  logic        rsp_add_rejected,
   input  logic        rsp_all_empty,
   output int          error_count,
   output int          pending_count,
   output int          served_total,
   output int          reject_total
);

   typedef struct packed {
      logic        served;
      logic [15:0] key;
      logic        finished;
      logic [31:0] tick;
      logic        rejected;
      logic        empty;
   } outcome_type;

   outcome_type outcome_q[$];

   logic [15:0]         ring_key[RT_DEPTH];
   logic [15:0]         ring_work[RT_DEPTH];
   int                  ring_head, ring_count;
   mlqs_pkg::entry_type store[READY_DEPTH];
   logic                turn_user;
   logic [31:0]         ticks;

   function automatic logic ahead_of(int a, int b);
      if (store[a].prio != store[b].prio) return store[a].prio > store[b].prio;
      if (store[a].user) begin
         if (store[a].last_use != store[b].last_use)
            return store[a].last_use < store[b].last_use;
      end else if (store[a].work != store[b].work) begin
         return store[a].work < store[b].work;
      end
      return store[a].key < store[b].key;
   endfunction

   function automatic int best_of(logic user);
      int best;
      best = -1;
      for (int i = 0; i < READY_DEPTH; i++)
         if (store[i].valid && store[i].user == user && (best < 0 || ahead_of(i, best)))
            best = i;
      return best;
   endfunction

   task automatic schedule(input logic cmd, input logic [1:0] cls, input logic [15:0] key,
                           input logic [7:0] prio, input logic [15:0] work,
                           input logic [31:0] last);
      outcome_type o;
      int slot, sys, usr, s;
      logic [15:0] k, w;
      o = '0;
      if (cmd == mlqs_pkg::CMD_ADD) begin
         if (work == 0 || cls == mlqs_pkg::CLASS_BAD) begin
            o.rejected = 1'b1;
         end else if (cls == mlqs_pkg::CLASS_RT) begin
            if (ring_count >= RT_DEPTH) begin
               o.rejected = 1'b1;
            end else begin
               slot = (ring_head + ring_count) % RT_DEPTH;
               ring_key[slot] = key;
               ring_work[slot] = work;
               ring_count++;
            end
         end else begin
            slot = -1;
            for (int i = 0; i < READY_DEPTH; i++)
               if (!store[i].valid && slot < 0) slot = i;
            if (slot < 0) begin
               o.rejected = 1'b1;
            end else begin
               store[slot] = '{valid: 1'b1, user: (cls == mlqs_pkg::CLASS_USER), prio: prio,
                               work: work, key: key, last_use: last};
            end
         end
      end else begin
         o.tick = ticks;
         if (ring_count != 0) begin
            k = ring_key[ring_head];
            w = ring_work[ring_head] - 16'd1;
            ring_head = (ring_head + 1) % RT_DEPTH;
            ring_count--;
            o.served = 1'b1;
            o.key = k;
            if (w == 0) begin
               o.finished = 1'b1;
            end else begin
               slot = (ring_head + ring_count) % RT_DEPTH;
               ring_key[slot] = k;
               ring_work[slot] = w;
               ring_count++;
            end
         end else begin
            sys = best_of(1'b0);
            usr = best_of(1'b1);
            s = -1;
            if (!turn_user) begin
               if (sys >= 0) begin
                  s = sys;
                  turn_user = 1'b1;
               end else s = usr;
            end else begin
               if (usr >= 0) begin
                  s = usr;
                  turn_user = 1'b0;
               end else s = sys;
            end
            if (s >= 0) begin
               o.served = 1'b1;
               o.key = store[s].key;
               store[s].work = store[s].work - 16'd1;
               store[s].last_use = ticks;
               if (store[s].work == 0) begin
                  o.finished = 1'b1;
                  store[s].valid = 1'b0;
               end
            end
         end
         ticks = ticks + 32'd1;
      end
      o.empty = (ring_count == 0);
      for (int i = 0; i < READY_DEPTH; i++)
         if (store[i].valid) o.empty = 1'b0;
      outcome_q.push_back(o);
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $error("%s expected %0h actual %0h", name, exp, act);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         outcome_q.delete();
         ring_head = 0;
         ring_count = 0;
         for (int i = 0; i < READY_DEPTH; i++) store[i] = '0;
         turn_user = 1'b0;
         ticks = '0;
         error_count = 0;
         served_total = 0;
         reject_total = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected transaction on rsp_");
               error_count++;
            end else begin
               e = outcome_q.pop_front();
               compare_field("served", e.served, rsp_served);
               compare_field("served_key", e.key, rsp_served_key);
               compare_field("finished", e.finished, rsp_finished);
               compare_field("tick_number", e.tick, rsp_tick_number);
               compare_field("add_rejected", e.rejected, rsp_add_rejected);
               compare_field("all_empty", e.empty, rsp_all_empty);
               served_total += rsp_served;
               reject_total += rsp_add_rejected;
            end
         end
         if (req_valid && !req_stall)
            schedule(req_cmd, req_job_class, req_name_key, req_priority_req,
                     req_work_units, req_last_use_init);
      end
      pending_count = outcome_q.size();
   end

endmodule

/* tb/tb_top.sv */
// top of the multilevel queue scheduler testbench: stimulus, receiver and verdict
`timescale 1ns / 100ps
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = mlqs_pkg::CMD_ADD;
   logic [1:0]  req_job_class = mlqs_pkg::CLASS_RT;
   logic [15:0] req_name_key = '0;
   logic [7:0]  req_priority_req = '0;
   logic [15:0] req_work_units = '0;
   logic [31:0] req_last_use_init = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_served;
   logic [15:0] rsp_served_key;
   logic        rsp_finished;
   logic [31:0] rsp_tick_number;
   logic        rsp_add_rejected;
   logic        rsp_all_empty;
   int          error_count, pending_count, served_total, reject_total;
   int          items_sent = 0;
   bit          long_hold = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   multilevel_queue_scheduler_core dut (.*);

   mlqs_checker checker_i (.*);

   task automatic offer(input logic cmd, input logic [1:0] cls, input logic [15:0] key,
                        input logic [7:0] prio, input logic [15:0] work,
                        input logic [31:0] last, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_job_class <= cls;
      req_name_key <= key;
      req_priority_req <= prio;
      req_work_units <= work;
      req_last_use_init <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic idle_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic random_add(input int key_span);
      logic [1:0] cls;
      logic [15:0] work;
      cls = $urandom_range(0, 9) == 0 ? mlqs_pkg::CLASS_BAD : 2'($urandom_range(0, 2));
      work = $urandom_range(0, 19) == 0 ? 16'($urandom) :
             ($urandom_range(0, 29) == 0 ? 16'd0 : 16'($urandom_range(1, 4)));
      offer(mlqs_pkg::CMD_ADD, cls, 16'($urandom_range(0, key_span)),
            8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)), work,
            $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20), 1'b1);
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      int stall_len;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            long_hold = 1'b0;
         end
         stall_len = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !long_hold);
         @(negedge clock);
      end
   end

   initial begin
      #50ms;
      $display("multilevel_queue_scheduler_core: mismatch");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      offer(mlqs_pkg::CMD_TICK, mlqs_pkg::CLASS_RT, 16'hffff, 8'hff, 16'hffff,
            32'hffffffff, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_RT, 16'h0000, 8'h00, 16'h0000, 32'h0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_BAD, 16'hffff, 8'hff, 16'hffff,
            32'hffffffff, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_RT, 16'hffff, 8'hff, 16'd2,
            32'hffffffff, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_RT, 16'h0001, 8'h00, 16'd1, 32'h0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_SYS, 16'h0010, 8'd5, 16'd3, 32'd0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_SYS, 16'h0011, 8'd5, 16'd3, 32'd0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_SYS, 16'h0011, 8'd5, 16'd3, 32'd0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_SYS, 16'h0012, 8'hff, 16'hffff, 32'd0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_USER, 16'h0020, 8'd7, 16'd1,
            32'hffffffff, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_USER, 16'h0021, 8'd7, 16'd2, 32'd0, 1'b0);
      offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_USER, 16'h0022, 8'd7, 16'd2, 32'd0, 1'b0);
      repeat (10)
         offer(mlqs_pkg::CMD_TICK, mlqs_pkg::CLASS_BAD, 16'h5a5a, 8'ha5, 16'h0, 32'h0, 1'b0);
      for (int i = 0; i < 17; i++)
         offer(mlqs_pkg::CMD_ADD, mlqs_pkg::CLASS_RT, 16'(i), 8'd0, 16'd1, 32'd0, 1'b0);
      for (int i = 0; i < 33; i++)
         offer(mlqs_pkg::CMD_ADD, i[0] ? mlqs_pkg::CLASS_USER : mlqs_pkg::CLASS_SYS, 16'(i),
               8'd1, 16'd1, 32'd0, 1'b0);
      idle_until_drained();

      // random part: mostly well-formed arrivals mixed with ticks
      while (items_sent < 800) begin
         if (items_sent == 400) begin
            long_hold = 1'b1;
            for (int i = 0; i < 20; i++) random_add(15);
         end
         if (items_sent == 600) idle_until_drained();
         if ($urandom_range(0, 9) < 5) random_add($urandom_range(0, 1) ? 15 : 65535);
         else offer(mlqs_pkg::CMD_TICK, 2'($urandom), 16'($urandom), 8'($urandom),
                    16'($urandom), $urandom, 1'b1);
      end
      idle_until_drained();
      repeat (100) @(negedge clock);

      $display("ran %0d transactions, %0d jobs served, %0d arrivals refused",
               items_sent, served_total, reject_total);
      if (error_count == 0 && pending_count == 0)
         $display("multilevel_queue_scheduler_core: match");
      else
         $display("multilevel_queue_scheduler_core: mismatch");
      $finish;
   end

endmodule
